### sv/ddzs_pkg.sv
// Package for the diamond-difference zone sweep block.
// Holds the item kinds, fixed field widths, saturation limits and the payload types.
package ddzs_pkg;

  localparam int VAL_W = 48;
  localparam int POS_W = 47;
  localparam int COS_W = 32;
  localparam int IDX_W = 5;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;

  localparam logic [KIND_W-1:0] KIND_ZONE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_X = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD_Y = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LOAD_Z = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ_X = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ_Y = 3'd5;
  localparam logic [KIND_W-1:0] KIND_READ_Z = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

  localparam logic [1:0] REG_COS_X = 2'd0;
  localparam logic [1:0] REG_COS_Y = 2'd1;
  localparam logic [1:0] REG_COS_Z = 2'd2;

  localparam logic signed [VAL_W-1:0] POS_LIM = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] NEG_LIM = 48'sh8000_0000_0000;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [IDX_W-1:0]        group;
    logic [IDX_W-1:0]        xi;
    logic [IDX_W-1:0]        yj;
    logic [IDX_W-1:0]        zk;
    logic signed [VAL_W-1:0] source_term;
    logic [POS_W-1:0]        total_xs;
    logic [POS_W-1:0]        width_x;
    logic [POS_W-1:0]        width_y;
    logic [POS_W-1:0]        width_z;
    logic signed [VAL_W-1:0] face_in;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] flux;
    logic [STAT_W-1:0]       status;
  } result_t;

  typedef struct packed {
    logic [1:0]        index;
    logic [COS_W-1:0]  data;
  } cfg_t;

endpackage

### sv/ddzs_if.sv
// Valid/ready channel interfaces for the zone sweep block.
// Depends on ddzs_pkg for the payload types.
interface ddzs_item_if (input logic clk);
  logic valid;
  logic ready;
  ddzs_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ddzs_result_if (input logic clk);
  logic valid;
  logic ready;
  ddzs_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ddzs_cfg_if (input logic clk);
  logic valid;
  logic ready;
  ddzs_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/ddzs_div.sv
// Bit-serial restoring divider: one numerator bit per cycle over a 128-bit numerator.
// Quotient is clamped to a limit below 2^48; depends on nothing outside this file.
module ddzs_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [63:0]  den,
  input  logic [47:0]  limit,
  output logic         done,
  output logic [47:0]  quo,
  output logic         over
);

  logic [127:0] shreg;
  logic [64:0]  rem;
  logic [48:0]  q;
  logic [47:0]  lim;
  logic [63:0]  d;
  logic [7:0]   cnt;
  logic         busy;
  logic         ov;
  logic [64:0]  rem_sh;
  logic [64:0]  rem_sub;
  logic         qb;
  logic [48:0]  q_next;

  // One restoring step on the shifted remainder.
  always_comb begin
    rem_sh  = {rem[63:0], shreg[127]};
    rem_sub = rem_sh - {1'b0, d};
    qb      = !rem_sub[64];
    q_next  = {q[47:0], qb};
  end

  // Step sequencer; the quotient stops growing once it passes the limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        shreg <= num;
        d     <= den;
        lim   <= limit;
        rem   <= '0;
        q     <= '0;
        ov    <= 1'b0;
      end else if (busy) begin
        shreg <= {shreg[126:0], 1'b0};
        rem   <= qb ? rem_sub : rem_sh;
        if (!ov) begin
          if (q_next > {1'b0, lim}) ov <= 1'b1;
          else q <= q_next;
        end
        cnt <= cnt + 8'd1;
        if (cnt == 8'd127) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo  = ov ? lim : q[47:0];
  assign over = ov;

endmodule

### sv/ddzs_mul.sv
// Digit-serial unsigned multiplier: 48-bit magnitude times 48-bit magnitude, 4 bits per cycle.
// Produces a 96-bit magnitude product; depends on nothing outside this file.
module ddzs_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] a,
  input  logic [47:0] b,
  output logic        done,
  output logic [95:0] prod
);

  logic [47:0] bs;
  logic [47:0] am;
  logic [3:0]  cnt;
  logic        busy;
  logic [51:0] part;

  // Multiply the multiplicand by the low four-bit digit of b.
  assign part = am * bs[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        am   <= a;
        bs   <= b;
        prod <= '0;
      end else if (busy) begin
        prod <= {({4'd0, prod[95:48]} + part), prod[47:4]};
        bs   <= {4'd0, bs[47:4]};
        cnt  <= cnt + 4'd1;
        if (cnt == 4'd11) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### sv/diamond_difference_zone_sweep.sv
// Diamond-difference zone sweep block: top level.
// Depends on ddzs_pkg, ddzs_if, ddzs_div and ddzs_mul.
//
// Usage: write cos_x, cos_y, cos_z (indexes 0..2) on the cfg channel while idle,
// then send items on in_ch. Load kinds write one face entry and give no result.
// Read kinds return one face entry with status 0 via S_RDWT, S_RDOUT and S_OUT.
// A zone item with nonzero widths and divisor runs three coefficient divisions
// on the shared bit-serial divider, three 48x48 products on the digit-serial
// multiplier, one flux division and three face write-backs; a zero width or
// divisor gives zero flux with status ST_ZERO. The divider takes one bit per cycle.
// One item is worked on at a time; in_ch.ready is high only when the block is
// idle and the output register is free. A finished result waits in the output
// register while out_ch.ready is low, and the block then takes no new item.
// Reset (rst, synchronous) clears control state and the cosines; face memories
// are undefined until loaded and need no clearing pass.
module diamond_difference_zone_sweep #(
  parameter int MAX_I  = 32,
  parameter int MAX_J  = 32,
  parameter int MAX_K  = 32,
  parameter int GROUPS = 32
) (
  input logic clk,
  input logic rst,
  ddzs_item_if.sink     in_ch,
  ddzs_result_if.source out_ch,
  ddzs_cfg_if.sink      cfg
);

  localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int IW = (MAX_I > 1) ? $clog2(MAX_I) : 1;
  localparam int JW = (MAX_J > 1) ? $clog2(MAX_J) : 1;
  localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int XA_W = GW + KW + JW;
  localparam int YA_W = GW + KW + IW;
  localparam int ZA_W = GW + JW + IW;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RDWT  = 5'd1;
  localparam logic [4:0] S_RDOUT = 5'd2;
  localparam logic [4:0] S_CDIV  = 5'd3;
  localparam logic [4:0] S_CWAIT = 5'd4;
  localparam logic [4:0] S_DEN   = 5'd5;
  localparam logic [4:0] S_MUL   = 5'd6;
  localparam logic [4:0] S_MWAIT = 5'd7;
  localparam logic [4:0] S_NUM   = 5'd8;
  localparam logic [4:0] S_PDIV  = 5'd9;
  localparam logic [4:0] S_PWAIT = 5'd10;
  localparam logic [4:0] S_WB    = 5'd11;
  localparam logic [4:0] S_OUT   = 5'd12;
  localparam logic [4:0] S_FETCH = 5'd13;

  logic [4:0] state;
  logic [1:0] axis;
  ddzs_pkg::item_t it;
  logic signed [31:0] cos_x, cos_y, cos_z;
  logic signed [47:0] x_faces [0:(1 << XA_W)-1];
  logic signed [47:0] y_faces [0:(1 << YA_W)-1];
  logic signed [47:0] z_faces [0:(1 << ZA_W)-1];
  logic signed [47:0] rd_x, rd_y, rd_z;
  logic [XA_W-1:0] xa;
  logic [YA_W-1:0] ya;
  logic [ZA_W-1:0] za;
  logic signed [47:0] cx, cy, cz;
  logic signed [47:0] fx, fy, fz;
  logic signed [49:0] den;
  logic signed [127:0] num;
  logic sat;
  logic signed [47:0] psi;
  ddzs_pkg::result_t res;
  logic out_valid;

  logic         d_start, d_done, d_over;
  logic [127:0] d_num;
  logic [63:0]  d_den;
  logic [47:0]  d_lim, d_quo;
  logic         m_start, m_done;
  logic [47:0]  m_a, m_b;
  logic [95:0]  m_prod;

  ddzs_div u_div (
    .clk(clk), .rst(rst), .start(d_start), .num(d_num), .den(d_den), .limit(d_lim),
    .done(d_done), .quo(d_quo), .over(d_over)
  );
  ddzs_mul u_mul (
    .clk(clk), .rst(rst), .start(m_start), .a(m_a), .b(m_b), .done(m_done),
    .prod(m_prod)
  );

  // Address formation with index reduction modulo the parameters.
  logic [GW-1:0] g_r;
  logic [IW-1:0] i_r;
  logic [JW-1:0] j_r;
  logic [KW-1:0] k_r;
  always_comb begin
    g_r = GW'(32'(it.group) % GROUPS);
    i_r = IW'(32'(it.xi) % MAX_I);
    j_r = JW'(32'(it.yj) % MAX_J);
    k_r = KW'(32'(it.zk) % MAX_K);
    xa  = XA_W'((32'(g_r) * MAX_K + 32'(k_r)) * MAX_J + 32'(j_r));
    ya  = YA_W'((32'(g_r) * MAX_K + 32'(k_r)) * MAX_I + 32'(i_r));
    za  = ZA_W'((32'(g_r) * MAX_J + 32'(j_r)) * MAX_I + 32'(i_r));
  end

  // Per-axis selection of cosine, width, face and coefficient.
  logic signed [31:0] cos_sel;
  logic [46:0]        w_sel;
  logic signed [47:0] f_sel, c_sel;
  logic [31:0]        cos_mag;
  logic [47:0]        f_mag, c_mag;
  logic signed [49:0] two_psi_m;
  logic               wb_sat;
  logic signed [47:0] wb_val;
  always_comb begin
    case (axis)
      2'd0:    begin cos_sel = cos_x; w_sel = it.width_x; f_sel = fx; c_sel = cx; end
      2'd1:    begin cos_sel = cos_y; w_sel = it.width_y; f_sel = fy; c_sel = cy; end
      default: begin cos_sel = cos_z; w_sel = it.width_z; f_sel = fz; c_sel = cz; end
    endcase
    cos_mag   = cos_sel[31] ? 32'(-cos_sel) : cos_sel;
    f_mag     = f_sel[47] ? 48'(-f_sel) : f_sel;
    c_mag     = c_sel[47] ? 48'(-c_sel) : c_sel;
    // 2*psi - face spans about three times the 48-bit range, so keep 50 bits.
    two_psi_m = {psi[47], psi, 1'b0} - {{2{f_sel[47]}}, f_sel};
    wb_sat    = (two_psi_m > 50'sh0_7FFF_FFFF_FFFF) || (two_psi_m < -50'sh0_8000_0000_0000);
    if (two_psi_m > 50'sh0_7FFF_FFFF_FFFF) wb_val = ddzs_pkg::POS_LIM;
    else if (two_psi_m < -50'sh0_8000_0000_0000) wb_val = ddzs_pkg::NEG_LIM;
    else wb_val = two_psi_m[47:0];
  end

  logic         num_neg;
  logic [127:0] num_mag;
  logic [49:0]  den_mag;
  logic         q_neg;
  assign num_neg = num[127];
  assign num_mag = num_neg ? 128'(-num) : num;
  assign den_mag = den[49] ? 50'(-den) : den;
  assign q_neg   = num_neg ^ den[49];

  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign cfg.ready   = 1'b1;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_x <= '0;
      cos_y <= '0;
      cos_z <= '0;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        ddzs_pkg::REG_COS_X: cos_x <= cfg.data.data;
        ddzs_pkg::REG_COS_Y: cos_y <= cfg.data.data;
        ddzs_pkg::REG_COS_Z: cos_z <= cfg.data.data;
        default: ;
      endcase
    end
  end

  // Face memories: registered reads, writes from loads and write-back.
  always_ff @(posedge clk) begin
    rd_x <= x_faces[xa];
    rd_y <= y_faces[ya];
    rd_z <= z_faces[za];
    if (state == S_WB) begin
      case (axis)
        2'd0:    x_faces[xa] <= wb_val;
        2'd1:    y_faces[ya] <= wb_val;
        default: z_faces[za] <= wb_val;
      endcase
    end else if (state == S_RDWT) begin
      case (it.kind)
        ddzs_pkg::KIND_LOAD_X: x_faces[xa] <= it.face_in;
        ddzs_pkg::KIND_LOAD_Y: y_faces[ya] <= it.face_in;
        ddzs_pkg::KIND_LOAD_Z: z_faces[za] <= it.face_in;
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      d_start   <= 1'b0;
      m_start   <= 1'b0;
      axis      <= '0;
    end else begin
      d_start <= 1'b0;
      m_start <= 1'b0;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && !out_valid) begin
            it    <= in_ch.data;
            state <= S_RDWT;
          end
        end
        S_RDWT: begin
          axis <= '0;
          sat  <= 1'b0;
          if (it.kind == ddzs_pkg::KIND_ZONE) begin
            if (it.width_x == '0 || it.width_y == '0 || it.width_z == '0) begin
              res.flux   <= '0;
              res.status <= ddzs_pkg::ST_ZERO;
              state      <= S_OUT;
            end else state <= S_CDIV;
          end else if (it.kind == ddzs_pkg::KIND_READ_X || it.kind == ddzs_pkg::KIND_READ_Y
                       || it.kind == ddzs_pkg::KIND_READ_Z) begin
            state <= S_RDOUT;
          end else state <= S_IDLE;
        end
        S_RDOUT: begin
          case (it.kind)
            ddzs_pkg::KIND_READ_X: res.flux <= rd_x;
            ddzs_pkg::KIND_READ_Y: res.flux <= rd_y;
            default:               res.flux <= rd_z;
          endcase
          res.status <= ddzs_pkg::ST_OK;
          state      <= S_OUT;
        end
        S_CDIV: begin
          d_start <= 1'b1;
          d_num   <= {61'd0, cos_mag, 35'd0};
          d_den   <= {17'd0, w_sel};
          d_lim   <= ddzs_pkg::POS_LIM;
          state   <= S_CWAIT;
        end
        S_CWAIT: begin
          if (d_done) begin
            if (d_over) sat <= 1'b1;
            case (axis)
              2'd0:    cx <= cos_sel[31] ? 48'(-d_quo) : d_quo;
              2'd1:    cy <= cos_sel[31] ? 48'(-d_quo) : d_quo;
              default: cz <= cos_sel[31] ? 48'(-d_quo) : d_quo;
            endcase
            if (axis == 2'd2) begin
              axis  <= '0;
              state <= S_DEN;
            end else begin
              axis  <= axis + 2'd1;
              state <= S_CDIV;
            end
          end
        end
        S_DEN: begin
          den   <= 50'(cx) + 50'(cy) + 50'(cz) + 50'({1'b0, it.total_xs});
          fx    <= rd_x;
          fy    <= rd_y;
          fz    <= rd_z;
          num   <= 128'(it.source_term) <<< 32;
          state <= S_FETCH;
        end
        S_FETCH: begin
          if (den == '0) begin
            res.flux   <= '0;
            res.status <= ddzs_pkg::ST_ZERO;
            state      <= S_OUT;
          end else state <= S_MUL;
        end
        S_MUL: begin
          m_start <= 1'b1;
          m_a     <= f_mag;
          m_b     <= c_mag;
          state   <= S_MWAIT;
        end
        S_MWAIT: begin
          if (m_done) begin
            if (f_sel[47] ^ c_sel[47]) num <= num - 128'(m_prod);
            else num <= num + 128'(m_prod);
            if (axis == 2'd2) begin
              axis  <= '0;
              state <= S_NUM;
            end else begin
              axis  <= axis + 2'd1;
              state <= S_MUL;
            end
          end
        end
        S_NUM: begin
          d_start <= 1'b1;
          d_num   <= num_mag;
          d_den   <= 64'(den_mag);
          d_lim   <= q_neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
          state   <= S_PWAIT;
        end
        S_PWAIT: begin
          if (d_done) begin
            if (d_over) sat <= 1'b1;
            psi   <= q_neg ? 48'(-d_quo) : d_quo;
            state <= S_WB;
          end
        end
        S_WB: begin
          if (wb_sat) sat <= 1'b1;
          if (axis == 2'd2) begin
            res.flux   <= psi;
            res.status <= (sat || wb_sat) ? ddzs_pkg::ST_SAT : ddzs_pkg::ST_OK;
            state      <= S_OUT;
          end
          axis <= axis + 2'd1;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/ddzs_checker.sv
// Port-level checker for the zone sweep block, bound to the top level.
// Depends on ddzs_pkg for the status codes.
module ddzs_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_status,
  input logic [47:0] out_flux
);

  // A result that waits stays valid and keeps its flux.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_flux))
    else $error("result changed while stalled");

  // No new item is taken while a result waits.
  a_noin: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("item taken while result pending");

  // A zero-divisor result carries zero flux.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ddzs_pkg::ST_ZERO |-> out_flux == '0)
    else $error("zero divisor with nonzero flux");

  // Status is never the unused code.
  a_stat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_status != 2'd3)
    else $error("bad status");

  // After an accepted item the block is busy next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after transfer");

endmodule

bind diamond_difference_zone_sweep ddzs_checker u_ddzs_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.data.status), .out_flux(out_ch.data.flux)
);
